[hw/rtl/mcec_pkg.sv]
package mcec_pkg;

  localparam int NUM_CARS_DEF = 4;
  localparam int NUM_FLOORS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int FLOOR_W = 4;
  localparam int RIDER_W = 6;
  localparam int CAR_W = 2;
  localparam int CNT_W = 7;
  localparam int ENTRY_W = 14;

  typedef enum logic [2:0] {
    ACT_ASSIGNED = 3'd0,
    ACT_REJECTED = 3'd1,
    ACT_IDLE     = 3'd2,
    ACT_OPENED   = 3'd3,
    ACT_CLOSED   = 3'd4,
    ACT_MOVED    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ENTERED = 2'd1,
    EV_EXITED  = 2'd2
  } rider_ev_t;

  typedef enum logic [1:0] {
    PH_ARRIVED = 2'd1,
    PH_OPEN    = 2'd2,
    PH_CLOSED  = 2'd3
  } door_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/multi_car_elevator_controller_unit.sv]
// Elevator dispatch for several cars. Each input transaction is a rider request (assigned to
// the car with the fewest pending requests, lowest index on ties) or a tick for one car that
// steps its door and motion machine; every transaction returns exactly one result. A
// transaction passes the accept in ST_IDLE, which also reads the rider queue memory, then
// ST_EXEC, which computes and writes back the scalar car state and the queue, then ST_OUT,
// which holds the result in the output register. The next transaction is taken only once
// that result has been accepted, so a low out_tready holds off the next transaction.
// The rider queues share one synchronous memory of NUM_CARS*QUEUE_DEPTH entries that is never
// cleared; only written slots are ever used.
module multi_car_elevator_controller_unit #(
  parameter int NUM_CARS = mcec_pkg::NUM_CARS_DEF,
  parameter int NUM_FLOORS = mcec_pkg::NUM_FLOORS_DEF,
  parameter int QUEUE_DEPTH = mcec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Bits from low: rider_id[5:0], origin_floor[9:6], target_floor[13:10],
  // car_index[15:14].
  input  logic [15:0] in_tdata,
  // req_type.
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Bits from low: action[2:0], car_out[4:3], move_dir[6:5], new_floor[10:7],
  // rider_event[12:11], rider_out[18:13], zero fill.
  output logic [23:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import mcec_pkg::*;

  localparam int CI_W = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D = NUM_CARS * QUEUE_DEPTH;
  localparam int MA_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam logic [FLOOR_W-1:0] FLOOR_MAX =
    (NUM_FLOORS - 1 > 15) ? 4'd15 : FLOOR_W'(NUM_FLOORS - 1);

  logic [ENTRY_W-1:0] qmem [MEM_D];
  logic [ENTRY_W-1:0] qrd_r;
  logic               qwe;
  logic [MA_W-1:0]    qwa, qra;
  logic [ENTRY_W-1:0] qwd;

  logic [FLOOR_W-1:0] floor_r [NUM_CARS];
  door_t              door_r [NUM_CARS];
  logic               loaded_r [NUM_CARS];
  logic [CNT_W-1:0]   pend_r [NUM_CARS];
  logic               aval_r [NUM_CARS];
  logic [ENTRY_W-1:0] arider_r [NUM_CARS];
  logic [QI_W-1:0]    head_r [NUM_CARS];
  logic [QF_W-1:0]    fill_r [NUM_CARS];

  logic [3:0] top_r;
  state_t state_r, state_nxt;
  logic          typ_r;
  logic [15:0]   dat_r;
  logic [CI_W-1:0] car_r;
  logic          car_ok_r;
  logic [23:0]   res_r, res_nxt;

  logic [CI_W-1:0] sel;
  logic [CI_W-1:0] tcar;
  logic            tcar_ok;

  always_comb begin
    sel = '0;
    for (int i = 1; i < NUM_CARS; i++) begin
      if (pend_r[i] < pend_r[sel]) sel = CI_W'(i);
    end
  end

  assign tcar = CI_W'(in_tdata[15:14]);
  assign tcar_ok = (32'(in_tdata[15:14]) < NUM_CARS);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = res_r;

  always_comb begin
    qra = '0;
    if (in_tuser) begin
      qra = MA_W'(32'(tcar) * QUEUE_DEPTH + 32'(head_r[tcar]));
    end
  end

  always_ff @(posedge clk) begin
    qrd_r <= qmem[qra];
    if (qwe) qmem[qwa] <= qwd;
  end

  // Compute stage.
  logic [FLOOR_W-1:0] fl, org, tgt, dst, top, nfl;
  logic [ENTRY_W-1:0] ar;
  logic               av, up;
  logic [QF_W-1:0]    fl_c;
  logic [QI_W-1:0]    slot;
  logic [QF_W:0]      slot_sum;
  logic [2:0]         act;
  logic [1:0]         mdir;
  logic [1:0]         rev;
  logic [RIDER_W-1:0] rid;
  logic               promote;

  always_comb begin
    qwe = 1'b0;
    qwa = '0;
    qwd = {dat_r[5:0], dat_r[9:6], dat_r[13:10]};
    act = ACT_IDLE;
    mdir = 2'd0;
    rev = EV_NONE;
    rid = '0;
    fl = floor_r[car_r];
    nfl = fl;
    fl_c = fill_r[car_r];
    promote = 1'b0;
    slot_sum = (QF_W+1)'(head_r[car_r]) + (QF_W+1)'(fl_c);
    slot = (slot_sum >= (QF_W+1)'(QUEUE_DEPTH)) ?
           QI_W'(slot_sum - (QF_W+1)'(QUEUE_DEPTH)) : QI_W'(slot_sum);
    av = aval_r[car_r];
    ar = arider_r[car_r];
    org = ar[7:4];
    tgt = ar[3:0];
    dst = '0;
    up = 1'b0;
    top = (top_r > FLOOR_MAX) ? FLOOR_MAX : top_r;
    if (state_r == ST_EXEC) begin
      if (!typ_r) begin
        if (fl_c >= QF_W'(QUEUE_DEPTH)) begin
          act = ACT_REJECTED;
        end else begin
          act = ACT_ASSIGNED;
          qwe = 1'b1;
          qwa = MA_W'(32'(car_r) * QUEUE_DEPTH + 32'(slot));
        end
      end else if (!car_ok_r) begin
        nfl = '0;
      end else begin
        if (!av && fl_c != '0) begin
          promote = 1'b1;
          av = 1'b1;
          ar = qrd_r;
        end
        org = ar[7:4];
        tgt = ar[3:0];
        if (av) begin
          case (door_r[car_r])
            PH_ARRIVED: begin
              act = ACT_OPENED;
              if (!loaded_r[car_r] && fl == org) begin
                rev = EV_ENTERED;
                rid = ar[13:8];
              end else if (loaded_r[car_r] && fl == tgt) begin
                rev = EV_EXITED;
                rid = ar[13:8];
              end
            end
            PH_OPEN: act = ACT_CLOSED;
            default: begin
              act = ACT_MOVED;
              dst = loaded_r[car_r] ? tgt : org;
              up = (dst > fl);
              if (fl == '0) up = 1'b1;
              else if (fl >= top) up = 1'b0;
              nfl = up ? fl + 1'b1 : fl - 1'b1;
              mdir = up ? 2'b01 : 2'b11;
            end
          endcase
        end
      end
    end
    res_nxt = {5'd0, rid, rev, nfl, mdir, typ_r ? dat_r[15:14] : 2'(sel), act};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      top_r <= 4'd15;
      for (int i = 0; i < NUM_CARS; i++) begin
        floor_r[i] <= '0;
        door_r[i] <= PH_CLOSED;
        loaded_r[i] <= 1'b0;
        pend_r[i] <= '0;
        aval_r[i] <= 1'b0;
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) top_r <= cfg_wr_data;
      if (state_r == ST_EXEC) begin
        res_r <= res_nxt;
        if (!typ_r) begin
          if (act == ACT_ASSIGNED) begin
            fill_r[car_r] <= fl_c + 1'b1;
            if (pend_r[car_r] != '1) pend_r[car_r] <= pend_r[car_r] + 1'b1;
          end
        end else if (car_ok_r) begin
          if (promote) begin
            arider_r[car_r] <= qrd_r;
            aval_r[car_r] <= 1'b1;
            head_r[car_r] <= (head_r[car_r] == QI_W'(QUEUE_DEPTH - 1)) ? '0 :
                             head_r[car_r] + 1'b1;
            fill_r[car_r] <= fl_c - 1'b1;
          end
          case (act)
            ACT_OPENED: begin
              door_r[car_r] <= PH_OPEN;
              if (rev == EV_ENTERED) loaded_r[car_r] <= 1'b1;
              if (rev == EV_EXITED) begin
                loaded_r[car_r] <= 1'b0;
                aval_r[car_r] <= 1'b0;
                if (pend_r[car_r] != '0) pend_r[car_r] <= pend_r[car_r] - 1'b1;
              end
            end
            ACT_CLOSED: door_r[car_r] <= PH_CLOSED;
            ACT_MOVED: begin
              floor_r[car_r] <= nfl;
              if (nfl == dst) door_r[car_r] <= PH_ARRIVED;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      typ_r <= in_tuser;
      dat_r <= in_tdata;
      car_r <= in_tuser ? tcar : sel;
      car_ok_r <= in_tuser ? tcar_ok : 1'b1;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (state_r == ST_OUT)) else $error("exec not followed by out");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= QF_W'(QUEUE_DEPTH)) else $error("queue overfill");
endmodule

[tb/multi_car_elevator_controller_unit_test.sv]
`timescale 1ns / 100ps

class dispatch_scoreboard;
  localparam int CARS = 4;
  localparam int QD = 16;

  logic [3:0] top_reg;
  logic [3:0] car_floor[CARS];
  mcec_pkg::door_t door[CARS];
  bit loaded[CARS];
  logic [6:0] pending[CARS];
  bit has_rider[CARS];
  logic [13:0] rider_cur[CARS];
  logic [13:0] fifo[CARS][QD];
  int head[CARS];
  int fill[CARS];
  logic [18:0] expected_q[$];
  int errors;
  int n_results;
  int n_enter;
  int n_exit;
  int n_reject;

  function void reset_state();
    top_reg = 4'd15;
    for (int c = 0; c < CARS; c++) begin
      car_floor[c] = '0;
      door[c] = mcec_pkg::PH_CLOSED;
      loaded[c] = 0;
      pending[c] = '0;
      has_rider[c] = 0;
      head[c] = 0;
      fill[c] = 0;
    end
    expected_q.delete();
  endfunction

  function void note_input(logic req, logic [15:0] d);
    mcec_pkg::action_t act;
    logic [1:0] car;
    logic [1:0] dir;
    logic [3:0] nf;
    mcec_pkg::rider_ev_t ev;
    logic [5:0] who;
    int sel;
    int c;
    int fl;
    int org;
    int tgt;
    int dest;
    int up;
    dir = 2'd0;
    ev = mcec_pkg::EV_NONE;
    who = '0;
    if (!req) begin
      sel = 0;
      for (int i = 1; i < CARS; i++) if (pending[i] < pending[sel]) sel = i;
      car = sel[1:0];
      if (fill[sel] >= QD) begin
        act = mcec_pkg::ACT_REJECTED;
      end else begin
        fifo[sel][(head[sel] + fill[sel]) % QD] = {d[5:0], d[9:6], d[13:10]};
        fill[sel]++;
        if (pending[sel] < 7'd127) pending[sel]++;
        act = mcec_pkg::ACT_ASSIGNED;
      end
      nf = car_floor[sel];
    end else begin
      c = d[15:14];
      car = d[15:14];
      if (!has_rider[c] && fill[c] > 0) begin
        rider_cur[c] = fifo[c][head[c]];
        head[c] = (head[c] + 1) % QD;
        fill[c]--;
        has_rider[c] = 1;
      end
      fl = car_floor[c];
      nf = car_floor[c];
      org = rider_cur[c][7:4];
      tgt = rider_cur[c][3:0];
      if (!has_rider[c]) begin
        act = mcec_pkg::ACT_IDLE;
      end else if (door[c] == mcec_pkg::PH_ARRIVED) begin
        door[c] = mcec_pkg::PH_OPEN;
        act = mcec_pkg::ACT_OPENED;
        if (!loaded[c] && fl == org) begin
          loaded[c] = 1;
          ev = mcec_pkg::EV_ENTERED;
          who = rider_cur[c][13:8];
        end else if (loaded[c] && fl == tgt) begin
          loaded[c] = 0;
          has_rider[c] = 0;
          if (pending[c] > 0) pending[c]--;
          ev = mcec_pkg::EV_EXITED;
          who = rider_cur[c][13:8];
        end
      end else if (door[c] == mcec_pkg::PH_OPEN) begin
        door[c] = mcec_pkg::PH_CLOSED;
        act = mcec_pkg::ACT_CLOSED;
      end else begin
        dest = loaded[c] ? tgt : org;
        up = dest > fl;
        if (fl == 0) up = 1;
        else if (fl >= top_reg) up = 0;
        fl = up ? fl + 1 : fl - 1;
        car_floor[c] = fl[3:0];
        if (fl == dest) door[c] = mcec_pkg::PH_ARRIVED;
        act = mcec_pkg::ACT_MOVED;
        dir = up ? 2'b01 : 2'b11;
        nf = fl[3:0];
      end
    end
    expected_q.push_back({who, ev, nf, dir, car, act});
  endfunction

  function void check_result(logic [23:0] got);
    logic [18:0] exp_r;
    n_results++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    exp_r = expected_q.pop_front();
    if (got[23:19] != '0) report_mismatch($sformatf("fill bits %h", got[23:19]));
    if (got[2:0] != exp_r[2:0])
      report_mismatch($sformatf("action %0d, expected %0d", got[2:0], exp_r[2:0]));
    if (got[4:3] != exp_r[4:3])
      report_mismatch($sformatf("car %0d, expected %0d", got[4:3], exp_r[4:3]));
    if (got[6:5] != exp_r[6:5])
      report_mismatch($sformatf("move_dir %0d, expected %0d", got[6:5], exp_r[6:5]));
    if (got[10:7] != exp_r[10:7])
      report_mismatch($sformatf("new_floor %0d, expected %0d", got[10:7], exp_r[10:7]));
    if (got[12:11] != exp_r[12:11])
      report_mismatch($sformatf("rider_event %0d, expected %0d", got[12:11], exp_r[12:11]));
    if (got[18:13] != exp_r[18:13])
      report_mismatch($sformatf("rider_out %0d, expected %0d", got[18:13], exp_r[18:13]));
    if (exp_r[2:0] == mcec_pkg::ACT_REJECTED) n_reject++;
    if (exp_r[12:11] == mcec_pkg::EV_ENTERED) n_enter++;
    if (exp_r[12:11] == mcec_pkg::EV_EXITED) n_exit++;
  endfunction

  function void report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("ERROR at %0t: %s", $time, msg);
  endfunction
endclass

module multi_car_elevator_controller_unit_test;
  import mcec_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic cfg_wr_en;
  logic [3:0] cfg_wr_data;

  dispatch_scoreboard sb;
  int idle_cycles;
  int burst_left;
  bit stall_on;

  multi_car_elevator_controller_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("multi_car_elevator_controller_unit: mismatch");
      $finish;
    end
  end

  // Receiver stalls in runs; some stretches never stall.
  always @(negedge clk) begin
    if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic send_item(logic req, logic [15:0] d);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(req, d);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_request(int id, int org, int tgt);
    send_item(1'b0, {2'($urandom), 4'(tgt), 4'(org), 6'(id)});
  endtask

  task automatic send_tick(int car);
    send_item(1'b1, {2'(car), 14'($urandom)});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_top(logic [3:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.top_reg = v;
  endtask

  task automatic random_phase(int n);
    int car;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        send_request($urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
        car = $urandom_range(0, 3);
        send_tick(car);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    stall_on = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_tick(0);
    send_request(63, 0, 0);
    send_request(0, 15, 15);
    send_request(21, 3, 1);
    send_request(42, 0, 15);
    for (int i = 0; i < 12; i++) send_tick(0);
    for (int i = 0; i < 6; i++) send_tick(3);
    drain();
    write_top(4'd1);
    send_request(7, 5, 9);
    for (int i = 0; i < 8; i++) send_tick($urandom_range(0, 3));

    write_top(4'd15);
    for (int i = 0; i < 40; i++) send_request($urandom_range(0, 63), 15, 0);
    random_phase(130);
    write_top(4'd7);
    random_phase(100);
    write_top(4'd0);
    random_phase(30);
    write_top(4'($urandom_range(1, 15)));
    random_phase(100);

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d results: %0d entries, %0d exits, %0d rejections",
             sb.n_results, sb.n_enter, sb.n_exit, sb.n_reject);
    $display("top floor settings 15, 1, 7, 0 and one random value");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("multi_car_elevator_controller_unit: match");
    end else begin
      $display("multi_car_elevator_controller_unit: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/mcec_pkg.sv
hw/rtl/multi_car_elevator_controller_unit.sv
tb/multi_car_elevator_controller_unit_test.sv
